@@ hdl/cde_pkg.sv @@
// ----------------------------------------------------------------------------
// Canvas draw engine package
// Shared sizes, codes, request structs and helper functions.
// ----------------------------------------------------------------------------
package cde_pkg;

	localparam int WIDTH        = 64;
	localparam int HEIGHT       = 64;
	localparam int HIST_RECORDS = 1024;
	localparam int HIST_ENTRIES = 64;

	localparam int MAX_DIM  = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
	localparam int FB_DEPTH = WIDTH * HEIGHT;
	localparam int FB_AW    = $clog2(FB_DEPTH);
	localparam int DIM_W    = $clog2(MAX_DIM + 1);
	localparam int REC_AW   = $clog2(HIST_RECORDS);
	localparam int REC_TW   = $clog2(HIST_RECORDS + 1);
	localparam int ENT_AW   = $clog2(HIST_ENTRIES);
	localparam int ENT_TW   = $clog2(HIST_ENTRIES + 1);
	localparam int CNT_W    = $clog2(MAX_DIM + 2);
	localparam int CW       = 12;
	localparam logic [23:0] WHITE = 24'hff_ffff;

	typedef enum logic [2:0] {
		MD_FILL   = 3'd0,
		MD_PIXEL  = 3'd1,
		MD_SQUARE = 3'd2,
		MD_LINE   = 3'd3,
		MD_UNDO   = 3'd4,
		MD_READ   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NO_UNDO = 2'd1,
		STS_FULL    = 2'd2,
		STS_RANGE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic signed [9:0] x_a;
		logic signed [9:0] y_a;
		logic signed [9:0] x_b;
		logic signed [9:0] y_b;
		logic [23:0]       rgb;
		logic [6:0]        square_size;
		logic              save_history;
	} cmd_t;

	typedef struct packed {
		logic [FB_AW-1:0] pix;
		logic [23:0]      rgb;
	} rec_t;

	typedef struct packed {
		logic             we;
		logic [FB_AW-1:0] waddr;
		logic [23:0]      wdata;
		logic             re;
		logic [FB_AW-1:0] raddr;
	} frame_req_t;

	typedef struct packed {
		logic              rec_we;
		logic [REC_AW-1:0] rec_waddr;
		rec_t              rec_wdata;
		logic              rec_re;
		logic [REC_AW-1:0] rec_raddr;
		logic              cnt_we;
		logic [ENT_AW-1:0] cnt_waddr;
		logic [CNT_W-1:0]  cnt_wdata;
		logic              cnt_re;
		logic [ENT_AW-1:0] cnt_raddr;
	} hist_req_t;

	// Register value limited to 1..limit.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [8:0] v, input int limit);
		logic [DIM_W-1:0] r;
		if (v == 9'd0) begin
			r = DIM_W'(1);
		end else if (int'(v) > limit) begin
			r = DIM_W'(limit);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	function automatic logic [FB_AW-1:0] pix_addr(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		return FB_AW'(int'(y) * WIDTH + int'(x));
	endfunction

	function automatic logic on_canvas(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		return !x[CW-1] && !y[CW-1] && (x < $signed(CW'(w))) && (y < $signed(CW'(h)));
	endfunction

endpackage

@@ hdl/canvas_draw_engine_with_undo_top.sv @@
// ----------------------------------------------------------------------------
// Canvas draw engine with undo
// RGB frame store with fill, pixel, square, line, undo and read commands.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   mode, x_a, y_a, x_b, y_b, red, green,
//                                            blue, square_size, save_history
// out       output     out_valid / out_stall status, read_red, read_green, read_blue
// cfg       input      cfg_we                cfg_index, cfg_data
//
// A request works through the single frame store port one access at a time: a
// line or pixel command writes each point and, for a point saved for undo, first
// reads its old color into a history record; fill and square write each covered
// pixel, and undo reads each record back and writes it into the frame store.
// After reset the block writes white to all FB_DEPTH (4096) frame store words and
// stalls the input meanwhile; configuration writes are taken at any time.
// The input stalls while a request is in work. A finished result sits in the
// output register, so the next request is taken while that result waits on stall.
// ----------------------------------------------------------------------------
module canvas_draw_engine_with_undo_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        mode,
	input  logic signed [9:0] x_a,
	input  logic signed [9:0] y_a,
	input  logic signed [9:0] x_b,
	input  logic signed [9:0] y_b,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [6:0]        square_size,
	input  logic              save_history,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [7:0]        read_red,
	output logic [7:0]        read_green,
	output logic [7:0]        read_blue,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [8:0]        cfg_data
);

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	logic [8:0]                   width_q, height_q;
	logic [cde_pkg::DIM_W-1:0]    w, h;
	cde_pkg::cmd_t                cmd;
	logic                         seq_idle, res_valid, res_ready;
	cde_pkg::status_t             res_status;
	logic [23:0]                  res_rgb;
	cde_pkg::frame_req_t          fr;
	logic [23:0]                  fr_rdata;
	cde_pkg::hist_req_t           hr;
	cde_pkg::rec_t                rec_rdata;
	logic [cde_pkg::CNT_W-1:0]    cnt_rdata;
	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic [23:0]                  rgb_q;

	// Registers are used clamped to the built canvas size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd64;
			height_q <= 9'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign w = cde_pkg::clamp_dim(width_q, cde_pkg::WIDTH);
	assign h = cde_pkg::clamp_dim(height_q, cde_pkg::HEIGHT);

	always_comb begin
		cmd.mode         = mode;
		cmd.x_a          = x_a;
		cmd.y_a          = y_a;
		cmd.x_b          = x_b;
		cmd.y_b          = y_b;
		cmd.rgb          = {red, green, blue};
		cmd.square_size  = square_size;
		cmd.save_history = save_history;
	end

	assign in_stall = !seq_idle;

	cde_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (in_valid),
		.cmd        (cmd),
		.w          (w),
		.h          (h),
		.res_ready  (res_ready),
		.idle       (seq_idle),
		.res_valid  (res_valid),
		.res_status (res_status),
		.res_rgb    (res_rgb),
		.fr         (fr),
		.fr_rdata   (fr_rdata),
		.hr         (hr),
		.rec_rdata  (rec_rdata),
		.cnt_rdata  (cnt_rdata)
	);

	cde_frame_mem u_frame (
		.clk   (clk),
		.req   (fr),
		.rdata (fr_rdata)
	);

	cde_hist_mem u_hist (
		.clk       (clk),
		.req       (hr),
		.rec_rdata (rec_rdata),
		.cnt_rdata (cnt_rdata)
	);

	// Output register: loads when empty or when its result is taken this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			status_q <= res_status;
			rgb_q    <= res_rgb;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_red   = rgb_q[23:16];
	assign read_green = rgb_q[15:8];
	assign read_blue  = rgb_q[7:0];

`ifndef SYNTHESIS
	// A taken request keeps the input stalled on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a taken request");

	// Only a successful read returns a color.
	a_color_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != cde_pkg::STS_OK) |->
		(read_red == 8'd0 && read_green == 8'd0 && read_blue == 8'd0))
		else $error("nonzero color with a failure status");

	// A new result is never produced while the held one is still stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !res_valid)
		else $error("result produced into a full output register");
`endif

endmodule

@@ hdl/cde_frame_mem.sv @@
// ----------------------------------------------------------------------------
// Frame store
// One write port and one registered read port over the RGB pixel array.
// ----------------------------------------------------------------------------
module cde_frame_mem (
	input  logic                clk,
	input  cde_pkg::frame_req_t req,
	output logic [23:0]         rdata
);

	logic [23:0] mem [cde_pkg::FB_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

@@ hdl/cde_hist_mem.sv @@
// ----------------------------------------------------------------------------
// Undo history stores
// Record store (pixel and old color) and per-entry record counts.
// ----------------------------------------------------------------------------
module cde_hist_mem (
	input  logic                         clk,
	input  cde_pkg::hist_req_t           req,
	output cde_pkg::rec_t                rec_rdata,
	output logic [cde_pkg::CNT_W-1:0]    cnt_rdata
);

	cde_pkg::rec_t                rec_mem [cde_pkg::HIST_RECORDS];
	logic [cde_pkg::CNT_W-1:0]    cnt_mem [cde_pkg::HIST_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.rec_we) begin
			rec_mem[req.rec_waddr] <= req.rec_wdata;
		end
		if (req.rec_re) begin
			rec_rdata <= rec_mem[req.rec_raddr];
		end
		if (req.cnt_we) begin
			cnt_mem[req.cnt_waddr] <= req.cnt_wdata;
		end
		if (req.cnt_re) begin
			cnt_rdata <= cnt_mem[req.cnt_raddr];
		end
	end

endmodule

@@ hdl/cde_seq.sv @@
// ----------------------------------------------------------------------------
// Command sequencer
// Walks fills, squares, lines and undo lists one frame store access at a time.
// ----------------------------------------------------------------------------
module cde_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  cde_pkg::cmd_t                 cmd,
	input  logic [cde_pkg::DIM_W-1:0]     w,
	input  logic [cde_pkg::DIM_W-1:0]     h,
	input  logic                          res_ready,
	output logic                          idle,
	output logic                          res_valid,
	output cde_pkg::status_t              res_status,
	output logic [23:0]                   res_rgb,
	output cde_pkg::frame_req_t           fr,
	input  logic [23:0]                   fr_rdata,
	output cde_pkg::hist_req_t            hr,
	input  cde_pkg::rec_t                 rec_rdata,
	input  logic [cde_pkg::CNT_W-1:0]     cnt_rdata
);

	localparam int CW = cde_pkg::CW;

	typedef enum logic [10:0] {
		ST_CLEAR    = 11'b000_0000_0001,
		ST_IDLE     = 11'b000_0000_0010,
		ST_RECT     = 11'b000_0000_0100,
		ST_PT       = 11'b000_0000_1000,
		ST_PT_WR    = 11'b000_0001_0000,
		ST_PUSH     = 11'b000_0010_0000,
		ST_UNDO_CNT = 11'b000_0100_0000,
		ST_UNDO_RD  = 11'b000_1000_0000,
		ST_UNDO_WR  = 11'b001_0000_0000,
		ST_READ     = 11'b010_0000_0000,
		ST_DONE     = 11'b100_0000_0000
	} state_t;

	state_t                         state_q;
	logic [cde_pkg::FB_AW-1:0]      clr_q;
	logic signed [CW-1:0]           x_q, y_q, x0_q, x1_q, y1_q;
	logic [23:0]                    rgb_q;
	logic                           save_q;
	logic [9:0]                     ax_q, ay_q, n_q, rx_q, ry_q, i_q, last_q;
	logic                           sgx_q, sgy_q;
	logic [cde_pkg::CNT_W-1:0]      cnt_q, c_q;
	logic [cde_pkg::REC_TW-1:0]     rec_top_q;
	logic [cde_pkg::ENT_TW-1:0]     ent_top_q;
	cde_pkg::status_t               status_q;
	logic [23:0]                    rd_q;

	logic signed [CW-1:0] xa, ya, dx, dy, adx, ady, sq_x0, sq_x1, sq_y0, sq_y1, sz;
	logic [9:0]           n_raw;
	logic                 room, on_pt, adv, rec_space;
	logic [cde_pkg::FB_AW-1:0] p;
	logic [10:0]          rx_sum, ry_sum;
	logic                 cy_x, cy_y;

	assign idle       = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_DONE) && res_ready;
	assign res_status = status_q;
	assign res_rgb    = rd_q;

	always_comb begin
		xa    = CW'(cmd.x_a);
		ya    = CW'(cmd.y_a);
		sz    = $signed(CW'(cmd.square_size));
		dx    = CW'(cmd.x_b) - xa;
		dy    = CW'(cmd.y_b) - ya;
		adx   = dx[CW-1] ? -dx : dx;
		ady   = dy[CW-1] ? -dy : dy;
		n_raw = (adx > ady) ? adx[9:0] : ady[9:0];
		if (n_raw == 10'd0) begin
			n_raw = 10'd1;
		end
		sq_x0 = xa - sz + CW'(1);
		sq_x1 = xa + sz - CW'(1);
		sq_y0 = ya - sz + CW'(1);
		sq_y1 = ya + sz - CW'(1);
		if (sq_x0[CW-1]) sq_x0 = '0;
		if (sq_y0[CW-1]) sq_y0 = '0;
		if (sq_x1 > $signed(CW'(w)) - CW'(1)) sq_x1 = $signed(CW'(w)) - CW'(1);
		if (sq_y1 > $signed(CW'(h)) - CW'(1)) sq_y1 = $signed(CW'(h)) - CW'(1);
		room = (int'(ent_top_q) < cde_pkg::HIST_ENTRIES) &&
			(int'(rec_top_q) + int'((w > h) ? w : h) + 1 <= cde_pkg::HIST_RECORDS);
	end

	// Incremental form of the truncating divide: remainder steps by |d| each point.
	always_comb begin
		rx_sum = 11'(rx_q) + 11'(ax_q);
		ry_sum = 11'(ry_q) + 11'(ay_q);
		cy_x   = rx_sum >= 11'(n_q);
		cy_y   = ry_sum >= 11'(n_q);
		p      = cde_pkg::pix_addr(x_q, y_q);
		on_pt  = cde_pkg::on_canvas(x_q, y_q, w, h);
		rec_space = int'(rec_top_q) < cde_pkg::HIST_RECORDS;
	end

	always_comb begin
		fr  = '0;
		hr  = '0;
		adv = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				fr.we    = 1'b1;
				fr.waddr = clr_q;
				fr.wdata = cde_pkg::WHITE;
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.mode == cde_pkg::MD_UNDO && ent_top_q != '0) begin
						hr.cnt_re    = 1'b1;
						hr.cnt_raddr = cde_pkg::ENT_AW'(ent_top_q - 1'b1);
					end
					if (cmd.mode == cde_pkg::MD_READ &&
							cde_pkg::on_canvas(xa, ya, w, h)) begin
						fr.re    = 1'b1;
						fr.raddr = cde_pkg::pix_addr(xa, ya);
					end
				end
			end
			ST_RECT: begin
				fr.we    = 1'b1;
				fr.waddr = p;
				fr.wdata = rgb_q;
			end
			ST_PT: begin
				if (on_pt && save_q && rec_space) begin
					fr.re    = 1'b1;
					fr.raddr = p;
				end else begin
					fr.we    = on_pt;
					fr.waddr = p;
					fr.wdata = rgb_q;
					adv      = 1'b1;
				end
			end
			ST_PT_WR: begin
				hr.rec_we        = 1'b1;
				hr.rec_waddr     = cde_pkg::REC_AW'(rec_top_q);
				hr.rec_wdata.pix = p;
				hr.rec_wdata.rgb = fr_rdata;
				fr.we            = 1'b1;
				fr.waddr         = p;
				fr.wdata         = rgb_q;
				adv              = 1'b1;
			end
			ST_PUSH: begin
				hr.cnt_we    = 1'b1;
				hr.cnt_waddr = cde_pkg::ENT_AW'(ent_top_q);
				hr.cnt_wdata = cnt_q;
			end
			ST_UNDO_RD: begin
				if (c_q != '0 && rec_top_q != '0) begin
					hr.rec_re    = 1'b1;
					hr.rec_raddr = cde_pkg::REC_AW'(rec_top_q - 1'b1);
				end
			end
			ST_UNDO_WR: begin
				fr.we    = 1'b1;
				fr.waddr = rec_rdata.pix;
				fr.wdata = rec_rdata.rgb;
			end
			ST_UNDO_CNT, ST_READ, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rec_top_q <= '0;
			ent_top_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == cde_pkg::FB_DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						status_q <= cde_pkg::STS_OK;
						rd_q     <= '0;
						rgb_q    <= cmd.rgb;
						state_q  <= ST_DONE;
						unique case (cmd.mode)
							cde_pkg::MD_FILL: begin
								x_q     <= '0;
								y_q     <= '0;
								x0_q    <= '0;
								x1_q    <= $signed(CW'(w)) - CW'(1);
								y1_q    <= $signed(CW'(h)) - CW'(1);
								state_q <= ST_RECT;
							end
							cde_pkg::MD_SQUARE: begin
								x_q  <= sq_x0;
								y_q  <= sq_y0;
								x0_q <= sq_x0;
								x1_q <= sq_x1;
								y1_q <= sq_y1;
								if (sq_x0 <= sq_x1 && sq_y0 <= sq_y1) begin
									state_q <= ST_RECT;
								end
							end
							cde_pkg::MD_PIXEL, cde_pkg::MD_LINE: begin
								x_q    <= xa;
								y_q    <= ya;
								rx_q   <= '0;
								ry_q   <= '0;
								i_q    <= '0;
								cnt_q  <= '0;
								sgx_q  <= dx[CW-1];
								sgy_q  <= dy[CW-1];
								n_q    <= n_raw;
								save_q <= cmd.save_history && room;
								if (cmd.mode == cde_pkg::MD_LINE) begin
									ax_q   <= adx[9:0];
									ay_q   <= ady[9:0];
									last_q <= n_raw;
								end else begin
									ax_q   <= '0;
									ay_q   <= '0;
									last_q <= '0;
								end
								if (cmd.mode == cde_pkg::MD_PIXEL &&
										!cde_pkg::on_canvas(xa, ya, w, h)) begin
									status_q <= cde_pkg::STS_RANGE;
								end else begin
									if (cmd.save_history && !room) begin
										status_q <= cde_pkg::STS_FULL;
									end
									state_q <= ST_PT;
								end
							end
							cde_pkg::MD_UNDO: begin
								if (ent_top_q == '0) begin
									status_q <= cde_pkg::STS_NO_UNDO;
								end else begin
									ent_top_q <= ent_top_q - 1'b1;
									state_q   <= ST_UNDO_CNT;
								end
							end
							cde_pkg::MD_READ: begin
								if (cde_pkg::on_canvas(xa, ya, w, h)) begin
									state_q <= ST_READ;
								end else begin
									status_q <= cde_pkg::STS_RANGE;
								end
							end
							default: begin
								status_q <= cde_pkg::STS_RANGE;
							end
						endcase
					end
				end
				ST_RECT: begin
					if (x_q == x1_q) begin
						x_q <= x0_q;
						if (y_q == y1_q) begin
							state_q <= ST_DONE;
						end else begin
							y_q <= y_q + CW'(1);
						end
					end else begin
						x_q <= x_q + CW'(1);
					end
				end
				ST_PT: begin
					if (!adv) begin
						state_q <= ST_PT_WR;
					end
				end
				ST_PT_WR: begin
					rec_top_q <= rec_top_q + 1'b1;
					cnt_q     <= cnt_q + 1'b1;
				end
				ST_PUSH: begin
					ent_top_q <= ent_top_q + 1'b1;
					state_q   <= ST_DONE;
				end
				ST_UNDO_CNT: begin
					c_q     <= cnt_rdata;
					state_q <= ST_UNDO_RD;
				end
				ST_UNDO_RD: begin
					if (c_q != '0 && rec_top_q != '0) begin
						rec_top_q <= rec_top_q - 1'b1;
						c_q       <= c_q - 1'b1;
						state_q   <= ST_UNDO_WR;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UNDO_WR: begin
					state_q <= ST_UNDO_RD;
				end
				ST_READ: begin
					rd_q    <= fr_rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Step to the next line point, or close the command after the last one.
			if (adv) begin
				if (i_q == last_q) begin
					state_q <= save_q ? ST_PUSH : ST_DONE;
				end else begin
					state_q <= ST_PT;
					i_q     <= i_q + 1'b1;
					rx_q    <= cy_x ? 10'(rx_sum - 11'(n_q)) : rx_sum[9:0];
					ry_q    <= cy_y ? 10'(ry_sum - 11'(n_q)) : ry_sum[9:0];
					if (cy_x) x_q <= sgx_q ? x_q - CW'(1) : x_q + CW'(1);
					if (cy_y) y_q <= sgy_q ? y_q - CW'(1) : y_q + CW'(1);
				end
			end
		end
	end

endmodule
